[src/stpic_pkg.sv]
// ----------------------------------------------------------------------------
// stpic_pkg
// Shared types, register map and gore tables for the sky tile converter.
// ----------------------------------------------------------------------------
package stpic_pkg;

	localparam int unsigned MAX_TILES_PER_FACET = 4096;

	localparam int unsigned TILE_W = 15;
	localparam int unsigned OUT_W  = 16;
	localparam int unsigned TPF_W  = 13;
	// multiples of the facet size, up to nine times an unchecked 13-bit value
	localparam int unsigned MULT_W = 17;
	// signed working width of the placement arithmetic
	localparam int unsigned SW     = 20;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_TPF  = 2'd0,
		REG_PROJ = 2'd1,
		REG_RAW  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PROJ_SAME  = 2'd0,
		PROJ_SHIFT = 2'd1,
		PROJ_XPH_N = 2'd2,
		PROJ_XPH_S = 2'd3
	} proj_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef struct packed {
		logic [TILE_W-1:0] tile_x;
		logic [TILE_W-1:0] tile_y;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_x;
		logic signed [OUT_W-1:0] out_y;
		logic                    valid_res;
	} out_t;

	typedef struct packed {
		logic [TPF_W-1:0] tpf;
		proj_t            proj;
		logic             raw;
	} cfg_t;

	// per-gore rotation and translation (in facets)
	localparam rot_t ROT_N [4] = '{ROT_0, ROT_90, ROT_180, ROT_270};
	localparam logic signed [3:0] XTR_N [4] = '{4'sd2, 4'sd1, -4'sd2, -4'sd3};
	localparam logic signed [3:0] YTR_N [4] = '{4'sd0, 4'sd1, 4'sd0, -4'sd3};
	localparam rot_t ROT_S [4] = '{ROT_90, ROT_0, ROT_270, ROT_180};
	localparam logic signed [3:0] XTR_S [4] = '{4'sd0, -4'sd1, 4'sd0, -4'sd1};
	localparam logic signed [3:0] YTR_S [4] = '{4'sd0, 4'sd1, 4'sd0, -4'sd3};

endpackage

[src/stpic_pipe.sv]
// ----------------------------------------------------------------------------
// stpic_pipe
// Five-register datapath: input capture, facet and gore classification,
// placement terms, rotation, final translation into the result register.
// ----------------------------------------------------------------------------
module stpic_pipe import stpic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_vld,
	input  in_t  in_req,
	output logic out_vld,
	output out_t out_res
);

	// facet size multiples, following the configuration
	logic [MULT_W-1:0] m_q [10];
	logic              n_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 10; i++) m_q[i] <= '0;
			n_bad_q <= 1'b1;
		end else begin
			for (int i = 0; i < 10; i++)
				m_q[i] <= MULT_W'(i) * MULT_W'(cfg.tpf);
			n_bad_q <= (cfg.tpf == '0) || (32'(cfg.tpf) > MAX_TILES_PER_FACET);
		end
	end

	// stage 1: capture
	logic              v_s1;
	logic [TILE_W-1:0] x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			x_s1 <= in_req.tile_x;
			y_s1 <= in_req.tile_y;
		end
	end

	// stage 2: classification
	logic [MULT_W-1:0] xe, ye, xpy1, y1;
	logic [5:1]        ge_x, ge_y;
	logic [2:0]        xf, yf, g_full;
	logic              off_facet, half, g_bad, wrap, unwrap, ok_c;
	logic              xph;

	always_comb begin
		xe   = MULT_W'(x_s1);
		ye   = MULT_W'(y_s1);
		xpy1 = xe + ye + MULT_W'(1);
		y1   = ye + MULT_W'(1);
		for (int k = 1; k <= 5; k++) begin
			ge_x[k] = xe >= m_q[k];
			ge_y[k] = ye >= m_q[k];
		end
		xf = 3'(ge_x[1]) + 3'(ge_x[2]) + 3'(ge_x[3]) + 3'(ge_x[4]);
		yf = 3'(ge_y[1]) + 3'(ge_y[2]) + 3'(ge_y[3]) + 3'(ge_y[4]);
		off_facet = ({1'b0, yf} > {1'b0, xf} + 4'd1) || ({1'b0, xf} > {1'b0, yf} + 4'd1);
		half = !cfg.raw && ((xpy1 < m_q[1]) || (xpy1 >= m_q[9]));
		g_full = 3'(xpy1 >= m_q[3]) + 3'(xpy1 >= m_q[5])
		       + 3'(xpy1 >= m_q[7]) + 3'(xpy1 >= m_q[9]);
		xph   = (cfg.proj == PROJ_XPH_N) || (cfg.proj == PROJ_XPH_S);
		g_bad = xph && (g_full > 3'd3);
		wrap   = ge_x[3] || ge_y[3] || (ge_x[2] && ge_y[2]);
		unwrap = wrap && !cfg.raw && (y1 < m_q[3]) && (xpy1 < m_q[5]);
		ok_c   = !n_bad_q && !ge_x[5] && !ge_y[5] && !off_facet && !half && !g_bad;
	end

	logic              v_s2, ok_s2, back_s2;
	logic [1:0]        g_s2;
	logic [TILE_W-1:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			g_s2    <= g_full[1:0];
			ok_s2   <= ok_c;
			back_s2 <= wrap && !unwrap;
		end
	end

	// stage 3: offset, rotation and translation terms
	logic signed [SW-1:0] off_c, eoff_c, tx_c, ty_c;
	logic signed [3:0]    kx, ky;
	rot_t                 rot_c;

	always_comb begin
		off_c = '0;
		rot_c = ROT_0;
		kx    = '0;
		ky    = '0;
		case (cfg.proj)
			PROJ_SAME: begin
				kx = '0;
				ky = '0;
			end
			PROJ_SHIFT: begin
				kx = back_s2 ? -4'sd2 : 4'sd2;
				ky = kx;
			end
			PROJ_XPH_N: begin
				off_c = SW'(m_q[{2'b00, g_s2}]);
				rot_c = ROT_N[g_s2];
				kx    = $signed({2'b00, g_s2}) + XTR_N[g_s2];
				ky    = $signed({2'b00, g_s2}) + YTR_N[g_s2];
			end
			PROJ_XPH_S: begin
				off_c = SW'(m_q[{2'b00, g_s2}]);
				rot_c = ROT_S[g_s2];
				kx    = $signed({2'b00, g_s2}) + XTR_S[g_s2];
				ky    = $signed({2'b00, g_s2}) + YTR_S[g_s2];
			end
			default: begin
				off_c = '0;
			end
		endcase
		eoff_c = SW'(m_q[2]) - SW'(1) + off_c;
		tx_c   = SW'(kx) * SW'($signed({1'b0, cfg.tpf}));
		ty_c   = SW'(ky) * SW'($signed({1'b0, cfg.tpf}));
	end

	logic                 v_s3, ok_s3;
	logic [TILE_W-1:0]    x_s3, y_s3;
	logic signed [SW-1:0] off_s3, eoff_s3, tx_s3, ty_s3;
	rot_t                 rot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			ok_s3   <= ok_s2;
			off_s3  <= off_c;
			eoff_s3 <= eoff_c;
			tx_s3   <= tx_c;
			ty_s3   <= ty_c;
			rot_s3  <= rot_c;
		end
	end

	// stage 4: rotate within the gore
	logic signed [SW-1:0] dx, dy, edx, edy, rx_c, ry_c;

	always_comb begin
		dx  = SW'(x_s3) - off_s3;
		dy  = SW'(y_s3) - off_s3;
		edx = eoff_s3 - SW'(x_s3);
		edy = eoff_s3 - SW'(y_s3);
		case (rot_s3)
			ROT_0: begin
				rx_c = dx;
				ry_c = dy;
			end
			ROT_90: begin
				rx_c = edy;
				ry_c = dx;
			end
			ROT_180: begin
				rx_c = edx;
				ry_c = edy;
			end
			ROT_270: begin
				rx_c = dy;
				ry_c = edx;
			end
			default: begin
				rx_c = dx;
				ry_c = dy;
			end
		endcase
	end

	logic                 v_s4, ok_s4;
	logic signed [SW-1:0] rx_s4, ry_s4, tx_s4, ty_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			ok_s4 <= ok_s3;
			rx_s4 <= rx_c;
			ry_s4 <= ry_c;
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
		end
	end

	// stage 5: translate, zero bad tiles
	logic signed [SW-1:0] fx, fy;
	logic                 done_q;
	out_t                 res_q;

	assign fx = rx_s4 + tx_s4;
	assign fy = ry_s4 + ty_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			res_q.out_x     <= ok_s4 ? fx[OUT_W-1:0] : '0;
			res_q.out_y     <= ok_s4 ? fy[OUT_W-1:0] : '0;
			res_q.valid_res <= ok_s4;
		end
	end

	assign out_vld = done_q;
	assign out_res = res_q;

endmodule

[src/sky_tile_projection_index_convert.sv]
// ----------------------------------------------------------------------------
// sky_tile_projection_index_convert
// Maps a tile index of the 5x5-facet sky grid into a target projection.
// ----------------------------------------------------------------------------
// Use:
//   A request (tile_x, tile_y in req) is taken at an edge with start high and
//   busy low. busy is always low: one request may enter every cycle.
//   Each result appears on res for exactly one cycle with done high, once it
//   has passed four pipeline registers (capture, classification, placement
//   terms, rotation) and then the result register. Results come out in
//   request order, one per request.
//   The receiver cannot hold results off; none is needed, as the pipeline
//   never stalls.
//   Tiles off the facets, in the unused half facets (unless raw_mode is set),
//   outside the grid, in a gore beyond the fourth (XPH projections only), or
//   with a bad facet size, give valid_res low and zero coordinates.
//   Registers on the APB port: 0x0 tiles_per_facet, 0x4 projection,
//   0x8 raw_mode. Write them only while no request is in flight.
//   Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module sky_tile_projection_index_convert import stpic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_t               req,
	output logic              done,
	output out_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [TPF_W-1:0] tiles_per_facet_q;
	proj_t            projection_q;
	logic             raw_mode_q;
	logic             wr;
	reg_idx_t         widx;
	cfg_t             cfg;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_per_facet_q <= TPF_W'(64);
			projection_q      <= PROJ_SAME;
			raw_mode_q        <= 1'b0;
		end else if (wr) begin
			case (widx)
				REG_TPF:  tiles_per_facet_q <= pwdata[TPF_W-1:0];
				REG_PROJ: projection_q      <= proj_t'(pwdata[1:0]);
				REG_RAW:  raw_mode_q        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_TPF:  prdata = DATA_W'(tiles_per_facet_q);
			REG_PROJ: prdata = DATA_W'(projection_q);
			REG_RAW:  prdata = DATA_W'(raw_mode_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.tpf  = tiles_per_facet_q;
	assign cfg.proj = projection_q;
	assign cfg.raw  = raw_mode_q;

	stpic_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_vld  (start && !busy),
		.in_req  (req),
		.out_vld (done),
		.out_res (res)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("request without result five cycles later");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("result without request");

	a_zero_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.valid_res) |-> (res.out_x == '0 && res.out_y == '0))
		else $error("bad tile with nonzero coordinates");

	a_zero_tpf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tiles_per_facet_q == '0) |-> !res.valid_res)
		else $error("valid result with zero facet size");

endmodule
